// ===== rtl/msmp_pkg.sv =====
package msmp_pkg;

  localparam int DEF_MAX_LEN    = 1024;
  localparam int DEF_VALUE_BITS = 24;
  localparam int PROD_W         = 58;
  localparam int MOD_W          = 30;
  localparam int QUEUE_DEPTH    = 4;

  localparam logic [MOD_W-1:0] MODULUS = 30'd1000000007;

  // Reciprocal of the modulus scaled by two to the power of twice its width.
  localparam logic [MOD_W:0] MOD_RECIP =
    (MOD_W + 1)'((64'd1 << (2 * MOD_W)) / 64'(MODULUS));

  typedef struct packed {
    logic last;
    logic skip;
  } item_flags_t;

endpackage

// ===== rtl/msmp_ram.sv =====
module msmp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/msmp_mod.sv =====
module msmp_mod (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [msmp_pkg::PROD_W-1:0] operand,
  output logic                        done,
  output logic [msmp_pkg::MOD_W-1:0]  result
);

  localparam int Q1_W = msmp_pkg::PROD_W - msmp_pkg::MOD_W + 1;
  localparam int MU_W = msmp_pkg::MOD_W + 1;
  localparam int Q2_W = Q1_W + MU_W;
  localparam int R_W  = msmp_pkg::MOD_W + 2;

  localparam logic [R_W-1:0] M1 = R_W'(msmp_pkg::MODULUS);
  localparam logic [R_W-1:0] M2 = M1 + M1;

  logic [2:0]                  stage_r;
  logic                        done_r;
  logic [msmp_pkg::PROD_W-1:0] opnd_r;
  logic [Q2_W-1:0]             q2_r;
  logic [R_W-1:0]              qm_r;
  logic [msmp_pkg::MOD_W-1:0]  rem_r;
  logic [R_W-1:0]              diff;
  logic [R_W-1:0]              red;

  // The quotient estimate is at most two below the true quotient, so the
  // remainder candidate lies below three times the modulus.
  assign diff = opnd_r[R_W-1:0] - qm_r;

  always_comb begin
    if (diff >= M2) begin
      red = diff - M2;
    end else if (diff >= M1) begin
      red = diff - M1;
    end else begin
      red = diff;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r <= '0;
      done_r  <= 1'b0;
    end else begin
      stage_r <= {stage_r[1:0], start};
      done_r  <= stage_r[2];
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      opnd_r <= operand;
    end
    if (stage_r[0]) begin
      q2_r <= Q2_W'(opnd_r[msmp_pkg::PROD_W-1 -: Q1_W]) * Q2_W'(msmp_pkg::MOD_RECIP);
    end
    if (stage_r[1]) begin
      qm_r <= R_W'(q2_r[Q2_W-1 -: Q1_W]) * R_W'(msmp_pkg::MODULUS);
    end
    if (stage_r[2]) begin
      rem_r <= red[msmp_pkg::MOD_W-1:0];
    end
  end

  assign done   = done_r;
  assign result = rem_r;

endmodule

// ===== rtl/msmp_fifo.sv =====
module msmp_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  assign full  = (count_r == CNT_W'(DEPTH));
  assign empty = (count_r == '0);
  assign rdata = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

// ===== rtl/msmp_front.sv =====
module msmp_front #(
  parameter int MAX_LEN    = msmp_pkg::DEF_MAX_LEN,
  parameter int VALUE_BITS = msmp_pkg::DEF_VALUE_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [VALUE_BITS-1:0] in_element_value,
  input  logic                  in_is_last,
  output logic                  q_push,
  output logic [VALUE_BITS-1:0] q_value,
  output msmp_pkg::item_flags_t q_flags,
  input  logic                  q_full
);

  localparam int CNT_W = $clog2(MAX_LEN + 1);

  logic [CNT_W-1:0] elem_cnt_r;
  logic             at_limit;

  assign at_limit = (elem_cnt_r == CNT_W'(MAX_LEN));
  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;
  assign q_value  = in_element_value;

  always_comb begin
    q_flags      = '0;
    q_flags.last = in_is_last;
    q_flags.skip = at_limit;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      elem_cnt_r <= '0;
    end else if (q_push) begin
      if (in_is_last) begin
        elem_cnt_r <= '0;
      end else if (!at_limit) begin
        elem_cnt_r <= elem_cnt_r + CNT_W'(1);
      end
    end
  end

endmodule

// ===== rtl/msmp_engine.sv =====
module msmp_engine #(
  parameter int MAX_LEN    = msmp_pkg::DEF_MAX_LEN,
  parameter int VALUE_BITS = msmp_pkg::DEF_VALUE_BITS
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        q_valid,
  output logic                        q_pop,
  input  logic [VALUE_BITS-1:0]       q_value,
  input  msmp_pkg::item_flags_t       q_flags,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [msmp_pkg::PROD_W-1:0] out_best_product,
  output logic [msmp_pkg::MOD_W-1:0]  out_best_product_mod,
  output logic                        out_length_error
);

  localparam int SUM_W  = VALUE_BITS + $clog2(MAX_LEN);
  localparam int CNT_W  = $clog2(MAX_LEN + 1);
  localparam int ADDR_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int ENT_W  = VALUE_BITS + SUM_W;
  localparam int FULL_W = SUM_W + VALUE_BITS;
  localparam int EXT_W  = (FULL_W > msmp_pkg::PROD_W) ? FULL_W : msmp_pkg::PROD_W;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_CMP  = 6'b000010,
    S_POP  = 6'b000100,
    S_SEED = 6'b001000,
    S_MOD  = 6'b010000,
    S_HOLD = 6'b100000
  } state_t;

  state_t                      state_r, state_nxt;
  logic [CNT_W-1:0]            count_r, count_nxt;
  logic [SUM_W-1:0]            run_r, run_nxt;
  logic [msmp_pkg::PROD_W-1:0] best_r, best_nxt;
  logic                        ovf_r, ovf_nxt;
  logic                        drain_r, drain_nxt;
  logic                        prod_v_r, prod_v_nxt;
  logic                        load_r, load_nxt;
  logic                        out_valid_r, out_valid_nxt;

  logic [VALUE_BITS-1:0]       top_v_r, top_v_nxt;
  logic [SUM_W-1:0]            top_s_r, top_s_nxt;
  logic [VALUE_BITS-1:0]       below_v_r, below_v_nxt;
  logic [SUM_W-1:0]            below_s_r, below_s_nxt;
  logic [SUM_W-1:0]            span_r, span_nxt;
  logic [msmp_pkg::PROD_W-1:0] prod_r, prod_nxt;
  logic [VALUE_BITS-1:0]       cur_v_r, cur_v_nxt;
  msmp_pkg::item_flags_t       cur_f_r, cur_f_nxt;

  logic [msmp_pkg::PROD_W-1:0] out_prod_r;
  logic [msmp_pkg::MOD_W-1:0]  out_mod_r;
  logic                        out_err_r;
  logic                        out_load;

  logic [CNT_W+1:0]            cnt_x;
  logic [CNT_W+1:0]            rd_idx;
  logic                        has1, has2, has3;
  logic [SUM_W-1:0]            push_sum;
  logic [EXT_W-1:0]            prod_ext;

  logic                        ram_we, ram_re;
  logic [ENT_W-1:0]            ram_rdata;
  logic [VALUE_BITS-1:0]       rd_v;
  logic [SUM_W-1:0]            rd_s;

  logic                        mod_start, mod_done;
  logic [msmp_pkg::MOD_W-1:0]  mod_result;

  assign cnt_x    = {2'b00, count_r};
  assign rd_idx   = cnt_x - (CNT_W + 2)'(3);
  assign has1     = (count_r != '0);
  assign has2     = (cnt_x >= (CNT_W + 2)'(2));
  assign has3     = (cnt_x >= (CNT_W + 2)'(3));
  assign push_sum = run_r + SUM_W'(cur_v_r);
  assign prod_ext = EXT_W'(span_r) * EXT_W'(top_v_r);
  assign rd_v     = ram_rdata[ENT_W-1 -: VALUE_BITS];
  assign rd_s     = ram_rdata[SUM_W-1:0];

  msmp_ram #(
    .WIDTH (ENT_W),
    .DEPTH (MAX_LEN)
  ) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cnt_x[ADDR_W-1:0]),
    .wdata ({cur_v_r, push_sum}),
    .re    (ram_re),
    .raddr (rd_idx[ADDR_W-1:0]),
    .rdata (ram_rdata)
  );

  msmp_mod u_mod (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mod_start),
    .operand (best_r),
    .done    (mod_done),
    .result  (mod_result)
  );

  always_comb begin
    logic pop_go;
    logic take_next;
    state_nxt     = state_r;
    count_nxt     = count_r;
    run_nxt       = run_r;
    best_nxt      = best_r;
    ovf_nxt       = ovf_r;
    drain_nxt     = drain_r;
    prod_v_nxt    = 1'b0;
    load_nxt      = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    top_v_nxt     = top_v_r;
    top_s_nxt     = top_s_r;
    below_v_nxt   = load_r ? rd_v : below_v_r;
    below_s_nxt   = load_r ? rd_s : below_s_r;
    span_nxt      = span_r;
    prod_nxt      = prod_r;
    cur_v_nxt     = cur_v_r;
    cur_f_nxt     = cur_f_r;
    q_pop         = 1'b0;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    mod_start     = 1'b0;
    out_load      = 1'b0;
    pop_go        = 1'b0;
    take_next     = 1'b0;

    if (prod_v_r && (prod_r > best_r)) begin
      best_nxt = prod_r;
    end

    case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          take_next = 1'b1;
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        pop_go = has1 && (drain_r || (!cur_f_r.skip && (top_v_r >= cur_v_r)));
        if (pop_go) begin
          span_nxt  = run_r - (has2 ? below_s_nxt : '0);
          state_nxt = S_POP;
        end else if (drain_r) begin
          state_nxt = S_SEED;
        end else begin
          if (cur_f_r.skip) begin
            ovf_nxt = 1'b1;
          end else begin
            ram_we      = 1'b1;
            run_nxt     = push_sum;
            count_nxt   = count_r + CNT_W'(1);
            below_v_nxt = top_v_r;
            below_s_nxt = top_s_r;
            top_v_nxt   = cur_v_r;
            top_s_nxt   = push_sum;
          end
          if (cur_f_r.last) begin
            drain_nxt = 1'b1;
          end else if (q_valid) begin
            take_next = 1'b1;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_POP: begin
        prod_nxt   = prod_ext[msmp_pkg::PROD_W-1:0];
        prod_v_nxt = 1'b1;
        top_v_nxt  = below_v_r;
        top_s_nxt  = below_s_r;
        count_nxt  = count_r - CNT_W'(1);
        if (has3) begin
          ram_re   = 1'b1;
          load_nxt = 1'b1;
        end
        state_nxt = S_CMP;
      end
      S_SEED: begin
        mod_start = 1'b1;
        state_nxt = S_MOD;
      end
      S_MOD: begin
        if (mod_done) begin
          state_nxt = S_HOLD;
        end
      end
      S_HOLD: begin
        if (!out_valid_r || out_ready) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          count_nxt     = '0;
          run_nxt       = '0;
          best_nxt      = '0;
          ovf_nxt       = 1'b0;
          drain_nxt     = 1'b0;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (take_next) begin
      q_pop     = 1'b1;
      cur_v_nxt = q_value;
      cur_f_nxt = q_flags;
      drain_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      run_r       <= '0;
      best_r      <= '0;
      ovf_r       <= 1'b0;
      drain_r     <= 1'b0;
      prod_v_r    <= 1'b0;
      load_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      run_r       <= run_nxt;
      best_r      <= best_nxt;
      ovf_r       <= ovf_nxt;
      drain_r     <= drain_nxt;
      prod_v_r    <= prod_v_nxt;
      load_r      <= load_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    top_v_r   <= top_v_nxt;
    top_s_r   <= top_s_nxt;
    below_v_r <= below_v_nxt;
    below_s_r <= below_s_nxt;
    span_r    <= span_nxt;
    prod_r    <= prod_nxt;
    cur_v_r   <= cur_v_nxt;
    cur_f_r   <= cur_f_nxt;
    if (out_load) begin
      out_prod_r <= best_r;
      out_mod_r  <= mod_result;
      out_err_r  <= ovf_r;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_best_product     = out_prod_r;
  assign out_best_product_mod = out_mod_r;
  assign out_length_error     = out_err_r;

endmodule

// ===== rtl/max_subarray_min_product_unit.sv =====
// Each element is pushed in the compare state, entered via idle if the engine was idle, and
// each stack entry it pops adds a pop and a compare step; a four-item queue decouples input
// from the stack. After the last item leaves the queue come its push, a pop and compare step
// per remaining stack entry, the three-stage modulo reduction and the result register.
// Reset is synchronous and active low; it clears control state only, and the stack memory is
// never cleared because only entries below the stack count are read.
module max_subarray_min_product_unit #(
  parameter int MAX_LEN    = msmp_pkg::DEF_MAX_LEN,
  parameter int VALUE_BITS = msmp_pkg::DEF_VALUE_BITS
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [VALUE_BITS-1:0]       in_element_value,
  input  logic                        in_is_last,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [msmp_pkg::PROD_W-1:0] out_best_product,
  output logic [msmp_pkg::MOD_W-1:0]  out_best_product_mod,
  output logic                        out_length_error
);

  localparam int FLAG_W = $bits(msmp_pkg::item_flags_t);
  localparam int Q_W    = VALUE_BITS + FLAG_W;

  logic                  f_push;
  logic [VALUE_BITS-1:0] f_value;
  msmp_pkg::item_flags_t f_flags;
  logic                  q_full;
  logic                  q_empty;
  logic                  q_pop;
  logic [Q_W-1:0]        q_rdata;
  msmp_pkg::item_flags_t q_flags;

  assign q_flags = msmp_pkg::item_flags_t'(q_rdata[Q_W-1 -: FLAG_W]);

  msmp_front #(
    .MAX_LEN    (MAX_LEN),
    .VALUE_BITS (VALUE_BITS)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_element_value (in_element_value),
    .in_is_last       (in_is_last),
    .q_push           (f_push),
    .q_value          (f_value),
    .q_flags          (f_flags),
    .q_full           (q_full)
  );

  msmp_fifo #(
    .WIDTH (Q_W),
    .DEPTH (msmp_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (f_push),
    .wdata ({f_flags, f_value}),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  msmp_engine #(
    .MAX_LEN    (MAX_LEN),
    .VALUE_BITS (VALUE_BITS)
  ) u_engine (
    .clk                  (clk),
    .rst_n                (rst_n),
    .q_valid              (!q_empty),
    .q_pop                (q_pop),
    .q_value              (q_rdata[VALUE_BITS-1:0]),
    .q_flags              (q_flags),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_best_product     (out_best_product),
    .out_best_product_mod (out_best_product_mod),
    .out_length_error     (out_length_error)
  );

endmodule

// ===== bench/tb_max_subarray_min_product_unit.sv =====
`timescale 1ns / 1ps

module tb_max_subarray_min_product_unit;

  localparam int LIMIT = msmp_pkg::DEF_MAX_LEN;
  localparam int VBITS = msmp_pkg::DEF_VALUE_BITS;
  localparam int PROD_W = msmp_pkg::PROD_W;
  localparam int MOD_W = msmp_pkg::MOD_W;
  localparam logic [VBITS-1:0] TOP_VALUE = '1;
  localparam logic [63:0] PROD_MASK = (64'd1 << PROD_W) - 64'd1;

  typedef enum int {
    SHAPE_RANDOM,
    SHAPE_NARROW,
    SHAPE_RISING,
    SHAPE_FALLING,
    SHAPE_EXTREME,
    SHAPE_NEAR_TOP
  } shape_e;

  typedef struct {
    logic [PROD_W-1:0] product;
    logic [MOD_W-1:0] product_mod;
    logic length_error;
  } min_product_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic [VBITS-1:0] in_element_value;
  logic in_is_last;
  logic out_valid;
  logic out_ready;
  logic [PROD_W-1:0] out_best_product;
  logic [MOD_W-1:0] out_best_product_mod;
  logic out_length_error;

  min_product_t pending_products[$];
  min_product_t oldest;
  int mismatches = 0;
  int items_sent = 0;
  bit idle_on = 1'b1;
  int hold_cycles = 0;

  logic [VBITS-1:0] run_values[LIMIT];
  logic [63:0] run_prefix[LIMIT];
  int run_depth = 0;
  int run_length = 0;
  logic [63:0] total_sum = '0;
  logic [63:0] best_score = '0;
  bit too_long = 1'b0;

  max_subarray_min_product_unit dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_element_value(in_element_value),
    .in_is_last(in_is_last),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_best_product(out_best_product),
    .out_best_product_mod(out_best_product_mod),
    .out_length_error(out_length_error)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("Mismatches found");
    $finish;
  end

  function automatic void retire_top(input logic [63:0] end_sum);
    logic [63:0] base;
    logic [63:0] score;
    run_depth--;
    base = (run_depth > 0) ? run_prefix[run_depth-1] : 64'd0;
    score = ((end_sum - base) * {{(64-VBITS){1'b0}}, run_values[run_depth]}) & PROD_MASK;
    if (score > best_score) begin
      best_score = score;
    end
  endfunction

  function automatic void absorb_element(input logic [VBITS-1:0] value, input logic last);
    min_product_t result;
    logic [63:0] reduced;
    if (run_length >= LIMIT) begin
      too_long = 1'b1;
    end else begin
      while (run_depth > 0 && run_values[run_depth-1] >= value) begin
        retire_top(total_sum);
      end
      total_sum += {{(64-VBITS){1'b0}}, value};
      run_values[run_depth] = value;
      run_prefix[run_depth] = total_sum;
      run_depth++;
      run_length++;
    end
    if (last) begin
      while (run_depth > 0) begin
        retire_top(total_sum);
      end
      reduced = best_score % {{(64-MOD_W){1'b0}}, msmp_pkg::MODULUS};
      result.product = best_score[PROD_W-1:0];
      result.product_mod = reduced[MOD_W-1:0];
      result.length_error = too_long;
      pending_products.push_back(result);
      total_sum = '0;
      best_score = '0;
      too_long = 1'b0;
      run_length = 0;
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_products.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("Unexpected result: product %0d mod %0d error %0b", out_best_product,
                   out_best_product_mod, out_length_error);
        end
      end else begin
        oldest = pending_products.pop_front();
        if (out_best_product !== oldest.product || out_best_product_mod !== oldest.product_mod ||
            out_length_error !== oldest.length_error) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("Result mismatch: expected product %0d mod %0d error %0b, got %0d %0d %0b",
                     oldest.product, oldest.product_mod, oldest.length_error,
                     out_best_product, out_best_product_mod, out_length_error);
          end
        end
      end
    end
  end

  initial begin
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_ready <= 1'b0;
        repeat (hold_cycles) @(negedge clk);
        hold_cycles = 0;
        out_ready <= 1'b1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(negedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic send_element(input logic [VBITS-1:0] value, input logic last);
    int gap;
    gap = 0;
    @(negedge clk);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 17);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_element_value <= value;
    in_is_last <= last;
    do @(posedge clk); while (!in_ready);
    absorb_element(value, last);
    items_sent++;
  endtask

  task automatic idle_input();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    idle_input();
    while (pending_products.size() != 0) @(negedge clk);
  endtask

  function automatic logic [VBITS-1:0] next_value(input shape_e shape,
                                                  input logic [VBITS-1:0] prev);
    int step;
    longint grown;
    step = $urandom_range(0, 40000);
    case (shape)
      SHAPE_NARROW: begin
        return VBITS'($urandom_range(0, 7));
      end
      SHAPE_RISING: begin
        grown = longint'(prev) + step;
        return (grown > longint'(TOP_VALUE)) ? TOP_VALUE : VBITS'(grown);
      end
      SHAPE_FALLING: begin
        return (prev > step) ? VBITS'(prev - step) : '0;
      end
      SHAPE_EXTREME: begin
        case ($urandom_range(0, 2))
          0: return '0;
          1: return TOP_VALUE;
          default: return VBITS'($urandom_range(0, TOP_VALUE));
        endcase
      end
      SHAPE_NEAR_TOP: begin
        return TOP_VALUE - VBITS'($urandom_range(0, 7));
      end
      default: begin
        return VBITS'($urandom_range(0, TOP_VALUE));
      end
    endcase
  endfunction

  task automatic send_shaped_array(input shape_e shape, input int length);
    logic [VBITS-1:0] value;
    if (shape == SHAPE_FALLING) begin
      value = TOP_VALUE - VBITS'($urandom_range(0, 1000));
    end else begin
      value = VBITS'($urandom_range(0, 1000));
    end
    for (int i = 0; i < length; i++) begin
      value = next_value(shape, value);
      send_element(value, i == length - 1);
    end
  endtask

  task automatic send_fixed_array(input logic [VBITS-1:0] values[$]);
    foreach (values[i]) begin
      send_element(values[i], i == values.size() - 1);
    end
  endtask

  task automatic test_directed();
    send_fixed_array('{'0});
    send_fixed_array('{TOP_VALUE});
    send_fixed_array('{24'd5, 24'd5, 24'd5});
    send_fixed_array('{24'd1, 24'd2, 24'd3, 24'd4});
    send_fixed_array('{24'd4, 24'd3, 24'd2, 24'd1});
    send_fixed_array('{'0, TOP_VALUE, '0});
    send_fixed_array('{TOP_VALUE, TOP_VALUE, TOP_VALUE, TOP_VALUE});
    send_fixed_array('{24'd3, 24'd1, 24'd3});
    wait_drained();
  endtask

  task automatic test_length_limit();
    for (int i = 0; i < LIMIT + 3; i++) begin
      if (i < LIMIT) begin
        send_element(VBITS'(i * 16383 + $urandom_range(0, 16382)), 1'b0);
      end else begin
        send_element(VBITS'($urandom_range(0, TOP_VALUE)), i == LIMIT + 2);
      end
    end
    wait_drained();
  endtask

  task automatic test_output_stall();
    hold_cycles = 300;
    for (int n = 0; n < 30; n++) begin
      send_shaped_array(shape_e'($urandom_range(0, 5)), $urandom_range(1, 3));
    end
    wait_drained();
  endtask

  task automatic test_random_arrays();
    int pick;
    int length;
    while (items_sent < 1450) begin
      if (items_sent >= 1300) begin
        idle_on = 1'b0;
      end
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        length = $urandom_range(1, 12);
      end else if (pick < 95) begin
        length = $urandom_range(13, 60);
      end else begin
        length = $urandom_range(61, 300);
      end
      if (length > 1450 - items_sent) begin
        length = 1450 - items_sent;
      end
      send_shaped_array(shape_e'($urandom_range(0, 5)), length);
    end
    wait_drained();
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_element_value = '0;
    in_is_last = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_length_limit();
    test_output_stall();
    test_random_arrays();
    repeat (2200) @(negedge clk);
    if (mismatches == 0 && pending_products.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/msmp_pkg.sv
rtl/msmp_ram.sv
rtl/msmp_mod.sv
rtl/msmp_fifo.sv
rtl/msmp_front.sv
rtl/msmp_engine.sv
rtl/max_subarray_min_product_unit.sv
bench/tb_max_subarray_min_product_unit.sv
